// ----- design/tgc_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_pkg
// shared types, codes and constants of the touch gesture classifier
// ----------------------------------------------------------------------------
package tgc_pkg;

  localparam int COORD_BITS   = 10;
  localparam int STEP_BITS    = 8;
  localparam int RATIO_BITS   = 6;
  localparam int CNT_BITS     = 6;
  localparam int IN_BYTES     = 3;
  localparam int OUT_BYTES    = 1;
  localparam int CFG_AW       = 5;
  localparam int CFG_DW       = 32;
  localparam int Q_DEPTH      = 4;
  localparam int Q_PTR_BITS   = 2;

  localparam logic [STEP_BITS-1:0] MIN_ROW_STEP = 8'd16;
  localparam logic [CNT_BITS-1:0]  LAST_STEP    = 6'd63;

  typedef logic [COORD_BITS-1:0] coord_t;

  typedef enum logic [1:0] {
    ACT_DOWN   = 2'd0,
    ACT_MOVE   = 2'd1,
    ACT_LIFT   = 2'd2,
    ACT_UNUSED = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    G_SCROLL_DOWN = 3'd0,
    G_SCROLL_UP   = 3'd1,
    G_TAP         = 3'd2,
    G_SWIPE_RIGHT = 3'd3,
    G_SWIPE_LEFT  = 3'd4
  } gesture_t;

  typedef enum logic [2:0] {
    REG_TAP_LIMIT  = 3'd0,
    REG_SWIPE_MIN  = 3'd1,
    REG_DOM_NUM    = 3'd2,
    REG_DOM_DEN    = 3'd3,
    REG_ROW_STEP   = 3'd4
  } reg_idx_t;

  typedef struct packed {
    logic [7:0]            tap_limit;
    logic [7:0]            swipe_minimum;
    logic [RATIO_BITS-1:0] dom_num;
    logic [RATIO_BITS-1:0] dom_den;
    logic [STEP_BITS-1:0]  row_step;
  } cfg_t;

  typedef struct packed {
    gesture_t gesture;
    logic     last;
  } word_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage
`default_nettype wire

// ----- design/tgc_cfg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_cfg
// apb register file holding the classifier thresholds
// ----------------------------------------------------------------------------
module tgc_cfg (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [tgc_pkg::CFG_AW-1:0] paddr,
  input  wire logic [tgc_pkg::CFG_DW-1:0] pwdata,
  output logic      [tgc_pkg::CFG_DW-1:0] prdata,
  output logic                            pready,
  output tgc_pkg::cfg_t                   cfg
);
  import tgc_pkg::*;

  cfg_t     cfg_r;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tap_limit     <= 8'd12;
      cfg_r.swipe_minimum <= 8'd30;
      cfg_r.dom_num       <= 6'd17;
      cfg_r.dom_den       <= 6'd10;
      cfg_r.row_step      <= 8'd45;
    end else if (wr_en) begin
      case (idx)
        REG_TAP_LIMIT: cfg_r.tap_limit     <= pwdata[7:0];
        REG_SWIPE_MIN: cfg_r.swipe_minimum <= pwdata[7:0];
        REG_DOM_NUM:   cfg_r.dom_num       <= pwdata[RATIO_BITS-1:0];
        REG_DOM_DEN:   cfg_r.dom_den       <= pwdata[RATIO_BITS-1:0];
        REG_ROW_STEP:  cfg_r.row_step      <= pwdata[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_TAP_LIMIT: prdata[7:0]            = cfg_r.tap_limit;
      REG_SWIPE_MIN: prdata[7:0]            = cfg_r.swipe_minimum;
      REG_DOM_NUM:   prdata[RATIO_BITS-1:0] = cfg_r.dom_num;
      REG_DOM_DEN:   prdata[RATIO_BITS-1:0] = cfg_r.dom_den;
      REG_ROW_STEP:  prdata[STEP_BITS-1:0]  = cfg_r.row_step;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ----- design/tgc_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_front
// accepts touch events, keeps the touch state and queues gesture words
// ----------------------------------------------------------------------------
module tgc_front (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire tgc_pkg::action_t   action,
  input  wire tgc_pkg::coord_t    pos_x,
  input  wire tgc_pkg::coord_t    pos_y,
  input  wire tgc_pkg::cfg_t      cfg,
  input  wire tgc_pkg::q_status_t q_stat,
  output logic                    push,
  output tgc_pkg::word_t          push_word
);
  import tgc_pkg::*;

  typedef enum logic {ST_IDLE, ST_STEP} state_t;

  state_t              state_r, state_nxt;
  coord_t              start_x_r, start_x_nxt;
  coord_t              start_y_r, start_y_nxt;
  coord_t              anchor_r, anchor_nxt;
  coord_t              y_r, y_nxt;
  logic                down_r, down_nxt;
  logic                armed_r, armed_nxt;
  logic                dragged_r, dragged_nxt;
  logic [CNT_BITS-1:0] cnt_r, cnt_nxt;

  logic [STEP_BITS-1:0]             step8;
  coord_t                           step;
  coord_t                           travel;
  coord_t                           rem;
  coord_t                           adx;
  coord_t                           ady;
  logic [COORD_BITS+RATIO_BITS-1:0] lhs;
  logic [COORD_BITS+RATIO_BITS-1:0] rhs;
  logic                             is_tap;
  logic                             is_swipe;
  logic                             last_step;

  assign step8     = (cfg.row_step < MIN_ROW_STEP) ? MIN_ROW_STEP : cfg.row_step;
  assign step      = coord_t'(step8);
  assign travel    = down_r ? (y_r - anchor_r) : (anchor_r - y_r);
  assign rem       = travel - step;
  assign last_step = (rem < step) || (cnt_r == LAST_STEP);

  assign adx = (pos_x >= start_x_r) ? (pos_x - start_x_r) : (start_x_r - pos_x);
  assign ady = (pos_y >= start_y_r) ? (pos_y - start_y_r) : (start_y_r - pos_y);
  assign lhs = adx * cfg.dom_den;
  assign rhs = ady * cfg.dom_num;
  assign is_tap   = (adx <= coord_t'(cfg.tap_limit)) && (ady <= coord_t'(cfg.tap_limit));
  assign is_swipe = (adx >= coord_t'(cfg.swipe_minimum)) && (lhs >= rhs);

  assign in_ready = (state_r == ST_IDLE) && !q_stat.full;

  always_comb begin
    state_nxt   = state_r;
    start_x_nxt = start_x_r;
    start_y_nxt = start_y_r;
    anchor_nxt  = anchor_r;
    y_nxt       = y_r;
    down_nxt    = down_r;
    armed_nxt   = armed_r;
    dragged_nxt = dragged_r;
    cnt_nxt     = cnt_r;
    push        = 1'b0;
    push_word   = '{gesture: G_TAP, last: 1'b1};
    case (state_r)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          case (action)
            ACT_DOWN: begin
              start_x_nxt = pos_x;
              start_y_nxt = pos_y;
              anchor_nxt  = pos_y;
              armed_nxt   = 1'b1;
              dragged_nxt = 1'b0;
            end
            ACT_MOVE: begin
              if (armed_r) begin
                y_nxt     = pos_y;
                down_nxt  = pos_y >= anchor_r;
                cnt_nxt   = '0;
                state_nxt = ST_STEP;
              end
            end
            ACT_LIFT: begin
              if (armed_r) begin
                armed_nxt = 1'b0;
                if (dragged_r) begin
                  dragged_nxt = 1'b0;
                end else if (is_tap) begin
                  push = 1'b1;
                end else if (is_swipe) begin
                  push              = 1'b1;
                  push_word.gesture = (pos_x > start_x_r) ? G_SWIPE_RIGHT : G_SWIPE_LEFT;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_STEP: begin
        if (!q_stat.full) begin
          if (travel >= step) begin
            push              = 1'b1;
            push_word.gesture = down_r ? G_SCROLL_DOWN : G_SCROLL_UP;
            push_word.last    = last_step;
            anchor_nxt        = down_r ? (anchor_r + step) : (anchor_r - step);
            dragged_nxt       = 1'b1;
            cnt_nxt           = cnt_r + 1'b1;
            if (last_step) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      start_x_r <= '0;
      start_y_r <= '0;
      anchor_r  <= '0;
      armed_r   <= 1'b0;
      dragged_r <= 1'b0;
      cnt_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      start_x_r <= start_x_nxt;
      start_y_r <= start_y_nxt;
      anchor_r  <= anchor_nxt;
      armed_r   <= armed_nxt;
      dragged_r <= dragged_nxt;
      cnt_r     <= cnt_nxt;
    end
    y_r    <= y_nxt;
    down_r <= down_nxt;
  end

endmodule
`default_nettype wire

// ----- design/tgc_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_fifo
// short word queue between the event front and the output stage
// ----------------------------------------------------------------------------
module tgc_fifo (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           push,
  input  wire tgc_pkg::word_t push_word,
  input  wire logic           pop,
  output tgc_pkg::word_t      head_word,
  output tgc_pkg::q_status_t  q_stat
);
  import tgc_pkg::*;

  word_t                 mem [Q_DEPTH];
  logic [Q_PTR_BITS-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_PTR_BITS-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_PTR_BITS:0]   count_r, count_nxt;
  logic                  do_push;
  logic                  do_pop;

  assign q_stat.full  = (count_r == (Q_PTR_BITS+1)'(Q_DEPTH));
  assign q_stat.empty = (count_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_word    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_word;
    end
  end

endmodule
`default_nettype wire

// ----- design/tgc_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tgc_back
// output register draining the word queue onto the result stream
// ----------------------------------------------------------------------------
module tgc_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire tgc_pkg::q_status_t q_stat,
  input  wire tgc_pkg::word_t     head_word,
  output logic                    pop,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output tgc_pkg::word_t          out_word
);
  import tgc_pkg::*;

  logic  valid_r, valid_nxt;
  word_t word_r, word_nxt;

  assign pop       = !q_stat.empty && (!valid_r || out_ready);
  assign out_valid = valid_r;
  assign out_word  = word_r;

  always_comb begin
    valid_nxt = valid_r;
    word_nxt  = word_r;
    if (pop) begin
      valid_nxt = 1'b1;
      word_nxt  = head_word;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    word_r <= word_nxt;
  end

endmodule
`default_nettype wire

// ----- design/touch_gesture_classifier_top.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// touch_gesture_classifier_top
// touch event stream in, gesture word stream out, apb threshold registers
// ----------------------------------------------------------------------------
// in_ carries one touch event per word; out_ carries gesture words, with
// out_tlast on the final word caused by an event. cfg_ is an apb port, one
// register every 4 bytes, pready always high.
// a liftoff that yields a gesture queues its word at accept; the word then
// passes through the queue and the output register to out_.
// a position update holds the event front while it emits n scroll words
// (at most 64), one per cycle while the queue is not full, or none when no
// step is due. the step loop subtracting row_step from the travel sets n.
// a four-word queue and the output register decouple the front from the
// receiver; when out_tready is low the queue fills and in_tready drops.
// reset disarms the touch, empties the queue and loads the register defaults.
// ----------------------------------------------------------------------------
module touch_gesture_classifier_top (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_tvalid,
  output logic                            in_tready,
  // action[1:0], pos_x[11:2], pos_y[21:12], zero fill
  input  wire logic [8*tgc_pkg::IN_BYTES-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  wire logic                       out_tready,
  // gesture[2:0], zero fill
  output logic      [8*tgc_pkg::OUT_BYTES-1:0] out_tdata,
  output logic                            out_tlast,
  input  wire logic                       cfg_psel,
  input  wire logic                       cfg_penable,
  input  wire logic                       cfg_pwrite,
  input  wire logic [tgc_pkg::CFG_AW-1:0] cfg_paddr,
  input  wire logic [tgc_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic      [tgc_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                            cfg_pready
);
  import tgc_pkg::*;

  cfg_t      cfg;
  q_status_t q_stat;
  logic      push;
  logic      pop;
  word_t     push_word;
  word_t     head_word;
  word_t     out_word;
  action_t   action;
  coord_t    pos_x;
  coord_t    pos_y;

  assign action = action_t'(in_tdata[1:0]);
  assign pos_x  = in_tdata[2+COORD_BITS-1:2];
  assign pos_y  = in_tdata[2+2*COORD_BITS-1:2+COORD_BITS];

  tgc_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  tgc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .action    (action),
    .pos_x     (pos_x),
    .pos_y     (pos_y),
    .cfg       (cfg),
    .q_stat    (q_stat),
    .push      (push),
    .push_word (push_word)
  );

  tgc_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_word (push_word),
    .pop       (pop),
    .head_word (head_word),
    .q_stat    (q_stat)
  );

  tgc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .head_word (head_word),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (out_word)
  );

  assign out_tdata = {{(8*OUT_BYTES-3){1'b0}}, out_word.gesture};
  assign out_tlast = out_word.last;

endmodule
`default_nettype wire
